// File: design/tsfp_pkg.sv
// types, constants and decode helpers for the tilt sensor frame parser
package tsfp_pkg;

  // frame layout
  localparam logic [3:0] IDLE_INDEX  = 4'd14;
  localparam logic [3:0] CHECK_INDEX = 4'd13;
  localparam logic [3:0] FIELD_FIRST = 4'd4;
  localparam logic [3:0] HDR_IDX_LEN = 4'd1;
  localparam logic [3:0] HDR_IDX_2   = 4'd2;
  localparam logic [3:0] HDR_IDX_3   = 4'd3;
  localparam int         FIELD_DEPTH = 9;

  // header contents
  localparam logic [7:0] HDR_BYTE0   = 8'h68;
  localparam logic [7:0] HDR_LEN_SUM = 8'h0D;
  localparam logic [7:0] HDR_BYTE2   = 8'h00;
  localparam logic [7:0] HDR_BYTE3   = 8'h84;
  localparam int         SIGN_BIT    = 4;

  // incoming word: one frame byte
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } byte_word_t;

  // outgoing word: one decoded frame
  typedef struct packed {
    logic               frame_ok;
    logic signed [15:0] x_hundredths;
    logic signed [15:0] y_hundredths;
    logic signed [15:0] temp_hundredths;
  } result_word_t;

  // two bcd nibbles, digits above nine used as they stand
  function automatic logic [7:0] bcd_value(input logic [7:0] b);
    logic [7:0] tens;
    tens = {4'd0, b[7:4]} * 8'd10;
    return tens + {4'd0, b[3:0]};
  endfunction

  // sign flag, whole part and hundredths into a signed value
  function automatic logic signed [15:0] decode_group(input logic [7:0] b0,
                                                      input logic [7:0] b1,
                                                      input logic [7:0] b2);
    logic [14:0] whole;
    logic [14:0] mag;
    whole = {7'd0, bcd_value(b1)} * 15'd100;
    mag   = whole + {7'd0, bcd_value(b2)};
    return b0[SIGN_BIT] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

endpackage

// File: design/tilt_sensor_frame_parser_unit.sv
// tilt sensor frame parser: byte register, frame state and result register
//
//   channel  | direction | word type      | handshake
//   byte     | in        | byte_word_t    | byte_valid / byte_stall
//   result   | out       | result_word_t  | result_valid / result_stall
//
// One byte is taken every cycle unless byte_stall holds it; each byte sits in
// the byte register while the frame state (count, checksum, header flag, field
// bytes) updates. As the checksum byte leaves the byte register, it loads the result register.
// rst clears the byte count, checksum, header flag, held values and both valids.
// A stalled result holds only a checksum byte in the byte register; other bytes
// keep flowing, so byte_stall rises only behind a waiting result word.
module tilt_sensor_frame_parser_unit
  import tsfp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         byte_valid,
  output logic         byte_stall,
  input  byte_word_t   byte_word,
  output logic         result_valid,
  input  logic         result_stall,
  output result_word_t result_word
);

  // byte register
  logic       s1_valid;
  byte_word_t s1_word;

  // frame state
  logic [3:0]         byte_index;
  logic [3:0]         byte_index_next;
  logic [7:0]         running_sum;
  logic [7:0]         running_sum_next;
  logic               header_bad;
  logic               header_bad_next;
  logic [7:0]         field_bytes [FIELD_DEPTH];
  logic signed [15:0] last_x;
  logic signed [15:0] last_y;
  logic signed [15:0] last_temp;

  logic [3:0]   idx;
  logic         s1_result;
  logic         s1_fire;
  logic         field_write;
  logic [3:0]   field_addr;
  logic [7:0]   sum_byte;
  result_word_t result_next;

  // position of the held byte
  assign idx = s1_word.frame_start ? 4'd0 : byte_index;
  assign s1_result = s1_valid && (idx == CHECK_INDEX);
  assign s1_fire = s1_valid && (!s1_result || !result_valid || !result_stall);
  assign byte_stall = s1_valid && !s1_fire;
  assign field_write = s1_fire && (idx >= FIELD_FIRST) && (idx <= 4'd12);
  assign field_addr = idx - FIELD_FIRST;
  assign sum_byte = (idx == HDR_IDX_LEN) ? HDR_LEN_SUM : s1_word.rx_byte;

  // frame state next values
  always_comb begin
    byte_index_next  = byte_index;
    running_sum_next = running_sum;
    header_bad_next  = header_bad;
    priority if (idx >= IDLE_INDEX) begin
      byte_index_next = byte_index;
    end else if (idx == 4'd0) begin
      running_sum_next = 8'd0;
      header_bad_next  = (s1_word.rx_byte != HDR_BYTE0);
      byte_index_next  = 4'd1;
    end else if (idx < CHECK_INDEX) begin
      running_sum_next = running_sum + sum_byte;
      if ((idx == HDR_IDX_2 && s1_word.rx_byte != HDR_BYTE2) ||
          (idx == HDR_IDX_3 && s1_word.rx_byte != HDR_BYTE3)) begin
        header_bad_next = 1'b1;
      end
      byte_index_next = idx + 4'd1;
    end else begin
      byte_index_next = IDLE_INDEX;
    end
  end

  // result word for the checksum byte
  always_comb begin
    result_next.frame_ok = !header_bad && (running_sum == s1_word.rx_byte);
    if (result_next.frame_ok) begin
      result_next.x_hundredths    = decode_group(field_bytes[0], field_bytes[1],
                                                 field_bytes[2]);
      result_next.y_hundredths    = decode_group(field_bytes[3], field_bytes[4],
                                                 field_bytes[5]);
      result_next.temp_hundredths = decode_group(field_bytes[6], field_bytes[7],
                                                 field_bytes[8]);
    end else begin
      result_next.x_hundredths    = last_x;
      result_next.y_hundredths    = last_y;
      result_next.temp_hundredths = last_temp;
    end
  end

  // byte register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!byte_stall) begin
      s1_valid <= byte_valid;
    end
    if (!byte_stall && byte_valid) begin
      s1_word <= byte_word;
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index  <= 4'd0;
      running_sum <= 8'd0;
      header_bad  <= 1'b0;
    end else if (s1_fire) begin
      byte_index  <= byte_index_next;
      running_sum <= running_sum_next;
      header_bad  <= header_bad_next;
    end
  end

  // field bytes of the current frame
  always_ff @(posedge clk) begin
    if (field_write) begin
      field_bytes[field_addr] <= s1_word.rx_byte;
    end
  end

  // held values and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      last_x       <= '0;
      last_y       <= '0;
      last_temp    <= '0;
      result_valid <= 1'b0;
    end else begin
      if (s1_fire && s1_result) begin
        last_x       <= result_next.x_hundredths;
        last_y       <= result_next.y_hundredths;
        last_temp    <= result_next.temp_hundredths;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
    if (s1_fire && s1_result) begin
      result_word <= result_next;
    end
  end

  // a stall only ever comes from a checksum byte behind a waiting result
  assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> (s1_result && result_valid && result_stall))
    else $error("byte stall without a waiting result");

  // a frame ends idle once its checksum byte has gone through
  assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_result) |=> (byte_index == IDLE_INDEX))
    else $error("frame not closed after checksum byte");

  // the shown values are always the held values
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result_word.x_hundredths == last_x &&
                      result_word.y_hundredths == last_y &&
                      result_word.temp_hundredths == last_temp))
    else $error("result values differ from held values");

  // byte count never passes the idle mark
  assert property (@(posedge clk) disable iff (rst)
    byte_index <= IDLE_INDEX)
    else $error("byte count out of range");

endmodule

// File: dv/tilt_sensor_frame_parser_unit_test.sv
// self-checking testbench for the tilt sensor frame parser unit
module tilt_sensor_frame_parser_unit_test;
  import tsfp_pkg::*;

  localparam int BYTE_TARGET = 1950;
  localparam int STUCK_LIMIT = 2000;
  localparam int LONG_HOLD   = 400;
  localparam int SETTLE      = 8;

  typedef enum int {
    FLAW_NONE,
    FLAW_HEADER,
    FLAW_CHECKSUM,
    FLAW_CUT
  } frame_flaw_e;

  typedef struct {
    byte_word_t word;
    bit         drain_first;
  } queued_byte_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         byte_valid = 1'b0;
  logic         byte_stall;
  byte_word_t   byte_word = '0;
  logic         result_valid;
  logic         result_stall = 1'b0;
  result_word_t result_word;

  // bytes still to send, decoded frames still to arrive
  queued_byte_t byte_q[$];
  result_word_t reading_q[$];

  // parser state as predicted
  logic [3:0]         frame_pos = 4'd0;
  logic [7:0]         chk_sum = 8'd0;
  logic               hdr_bad = 1'b0;
  logic [7:0]         field_store [FIELD_DEPTH];
  logic signed [15:0] held_x = '0;
  logic signed [15:0] held_y = '0;
  logic signed [15:0] held_temp = '0;

  int mismatches = 0;
  int queued_bytes = 0;
  int results_seen = 0;
  int tx_gap = 0;
  int tx_calm = 0;
  int rx_stall_left = 0;
  int rx_calm = 0;
  int hold_left = 0;
  bit long_hold_done = 1'b0;
  int stuck_cycles = 0;

  tilt_sensor_frame_parser_unit uut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_word    (byte_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_word  (result_word)
  );

  always #10 clk = ~clk;

  // gap length: mostly none or short, now and then long, with calm stretches
  function automatic int rand_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(30, 120);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // sign from the first byte, bcd whole part and hundredths
  function automatic logic signed [15:0] angle_of(input logic [7:0] sgn,
                                                  input logic [7:0] whole,
                                                  input logic [7:0] frac);
    int mag;
    mag = (int'(whole[7:4]) * 10 + int'(whole[3:0])) * 100
        + int'(frac[7:4]) * 10 + int'(frac[3:0]);
    return sgn[SIGN_BIT] ? 16'(-mag) : 16'(mag);
  endfunction

  // advance the predicted parser by one accepted byte word
  task automatic parse_byte(input byte_word_t w);
    logic [3:0]   pos;
    logic [7:0]   sum_in;
    result_word_t rw;
    pos = w.frame_start ? 4'd0 : frame_pos;
    if (pos >= IDLE_INDEX) begin
      // idle after a complete frame: byte ignored
    end else if (pos == 4'd0) begin
      chk_sum   = 8'd0;
      hdr_bad   = (w.rx_byte != HDR_BYTE0);
      frame_pos = 4'd1;
    end else if (pos < CHECK_INDEX) begin
      sum_in  = (pos == HDR_IDX_LEN) ? HDR_LEN_SUM : w.rx_byte;
      chk_sum = chk_sum + sum_in;
      if (pos == HDR_IDX_2 && w.rx_byte != HDR_BYTE2) hdr_bad = 1'b1;
      if (pos == HDR_IDX_3 && w.rx_byte != HDR_BYTE3) hdr_bad = 1'b1;
      if (pos >= FIELD_FIRST) field_store[pos - FIELD_FIRST] = w.rx_byte;
      frame_pos = pos + 4'd1;
    end else begin
      rw.frame_ok = !hdr_bad && (chk_sum == w.rx_byte);
      if (rw.frame_ok) begin
        held_x    = angle_of(field_store[0], field_store[1], field_store[2]);
        held_y    = angle_of(field_store[3], field_store[4], field_store[5]);
        held_temp = angle_of(field_store[6], field_store[7], field_store[8]);
      end
      rw.x_hundredths    = held_x;
      rw.y_hundredths    = held_y;
      rw.temp_hundredths = held_temp;
      reading_q.push_back(rw);
      frame_pos = IDLE_INDEX;
    end
  endtask

  task automatic push_byte(input logic [7:0] v, input logic st, input bit drain);
    queued_byte_t qb;
    qb.word.rx_byte     = v;
    qb.word.frame_start = st;
    qb.drain_first      = drain;
    byte_q.push_back(qb);
    queued_bytes++;
  endtask

  // queue one frame around nine field bytes, optionally damaged
  task automatic push_frame(input logic [71:0] fields, input logic [7:0] len_byte,
                            input frame_flaw_e flaw, input logic lead_start,
                            input bit drain);
    logic [7:0] fb [14];
    logic [7:0] sum;
    logic [7:0] flip;
    int         cut;
    int         which;
    fb[0] = HDR_BYTE0;
    fb[1] = len_byte;
    fb[2] = HDR_BYTE2;
    fb[3] = HDR_BYTE3;
    for (int i = 0; i < FIELD_DEPTH; i++) fb[4 + i] = fields[8 * i +: 8];
    // byte 1 always counts as the fixed length byte
    sum = HDR_LEN_SUM;
    for (int i = 2; i < 13; i++) sum = sum + fb[i];
    fb[13] = sum;
    cut  = 14;
    flip = 8'($urandom_range(1, 255));
    case (flaw)
      FLAW_HEADER: begin
        which = $urandom_range(0, 2);
        if (which == 0) fb[0] = fb[0] ^ flip;
        else if (which == 1) fb[2] = fb[2] ^ flip;
        else fb[3] = fb[3] ^ flip;
      end
      FLAW_CHECKSUM: begin
        fb[13] = fb[13] ^ flip;
      end
      FLAW_CUT: begin
        cut = $urandom_range(1, 13);
      end
      default: begin
      end
    endcase
    for (int i = 0; i < cut; i++)
      push_byte(fb[i], (i == 0) ? lead_start : 1'b0, (i == 0) && drain);
  endtask

  // three groups: mostly proper bcd, some raw bytes, some negative zero
  function automatic logic [71:0] rand_fields();
    logic [71:0] f;
    int          r;
    for (int g = 0; g < 3; g++) begin
      f[24 * g +: 8] = 8'($urandom_range(0, 255));
      r = $urandom_range(0, 99);
      if (r < 5) begin
        f[24 * g + 8 +: 16] = '0;
        f[24 * g + SIGN_BIT] = 1'b1;
      end else if (r < 75) begin
        f[24 * g + 8  +: 4] = 4'($urandom_range(0, 9));
        f[24 * g + 12 +: 4] = 4'($urandom_range(0, 9));
        f[24 * g + 16 +: 4] = 4'($urandom_range(0, 9));
        f[24 * g + 20 +: 4] = 4'($urandom_range(0, 9));
      end else begin
        f[24 * g + 8 +: 16] = 16'($urandom_range(0, 65535));
      end
    end
    return f;
  endfunction

  task automatic note_miss(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  // sender: presents queued words, holds a stalled word, random gaps
  always @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (byte_valid && !byte_stall) parse_byte(byte_word);
      if (!byte_valid || !byte_stall) begin
        if (tx_gap > 0) begin
          tx_gap--;
          byte_valid <= 1'b0;
        end else if (byte_q.size() > 0 &&
                     !(byte_q[0].drain_first && reading_q.size() > 0)) begin
          byte_word  <= byte_q[0].word;
          byte_valid <= 1'b1;
          byte_q.pop_front();
          tx_gap = rand_gap(tx_calm);
        end else begin
          byte_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each decoded frame, random stalls and one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        results_seen++;
        if (reading_q.size() == 0) begin
          note_miss($sformatf("result word with none pending: ok %0b x %0d y %0d t %0d",
                              result_word.frame_ok, result_word.x_hundredths,
                              result_word.y_hundredths, result_word.temp_hundredths));
        end else begin
          if (result_word.frame_ok !== reading_q[0].frame_ok)
            note_miss($sformatf("frame_ok expected %0b, got %0b",
                                reading_q[0].frame_ok, result_word.frame_ok));
          if (result_word.x_hundredths !== reading_q[0].x_hundredths)
            note_miss($sformatf("x_hundredths expected %0d, got %0d",
                                reading_q[0].x_hundredths, result_word.x_hundredths));
          if (result_word.y_hundredths !== reading_q[0].y_hundredths)
            note_miss($sformatf("y_hundredths expected %0d, got %0d",
                                reading_q[0].y_hundredths, result_word.y_hundredths));
          if (result_word.temp_hundredths !== reading_q[0].temp_hundredths)
            note_miss($sformatf("temp_hundredths expected %0d, got %0d",
                                reading_q[0].temp_hundredths,
                                result_word.temp_hundredths));
          reading_q.pop_front();
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (results_seen >= 30 && !long_hold_done) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
        result_stall <= 1'b1;
      end else if (rx_stall_left > 0) begin
        rx_stall_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
        rx_stall_left = rand_gap(rx_calm);
      end
    end
  end

  // watchdog on cycles where neither channel moves a word
  always @(posedge clk) begin
    if (rst) begin
      stuck_cycles = 0;
    end else begin
      if ((byte_valid && !byte_stall) || (result_valid && !result_stall))
        stuck_cycles = 0;
      else
        stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    int          pick;
    int          frames;
    frame_flaw_e flaw;
    logic        lead;
    // first frame after reset has no start flag; extreme and negative zero groups
    push_frame(72'h00_00_10_99_99_0F_FF_FF_FF, HDR_LEN_SUM, FLAW_NONE, 1'b0, 1'b0);
    // stray bytes after a complete frame are ignored
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    // frame broken off and restarted by the next start flag
    push_byte(HDR_BYTE0, 1'b1, 1'b0);
    push_byte(8'h5A, 1'b0, 1'b0);
    push_byte(HDR_BYTE2, 1'b0, 1'b0);
    push_byte(HDR_BYTE3, 1'b0, 1'b0);
    frames = 0;
    while (queued_bytes < BYTE_TARGET) begin
      pick = $urandom_range(0, 99);
      lead = 1'b1;
      if (pick < 70) flaw = FLAW_NONE;
      else if (pick < 78) flaw = FLAW_HEADER;
      else if (pick < 86) flaw = FLAW_CHECKSUM;
      else if (pick < 93) flaw = FLAW_CUT;
      else begin
        flaw = FLAW_NONE;
        lead = 1'b0;
      end
      if (pick >= 97) begin
        // noise with random start flags
        repeat ($urandom_range(1, 4))
          push_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0), 1'b0);
      end else begin
        push_frame(rand_fields(),
                   ($urandom_range(0, 1) == 0) ? HDR_LEN_SUM : 8'($urandom_range(0, 255)),
                   flaw, lead, (frames == 40) || ($urandom_range(0, 99) < 3));
        if ($urandom_range(0, 9) == 0)
          repeat ($urandom_range(1, 2))
            push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
      frames++;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    while (byte_q.size() != 0 || byte_valid || reading_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && reading_q.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: tilt_sensor_frame_parser_unit.f
design/tsfp_pkg.sv
design/tilt_sensor_frame_parser_unit.sv
dv/tilt_sensor_frame_parser_unit_test.sv
